[src/rcre_pkg.sv]
// Package of the row-copy run-length image encoder.
// Holds the command type passed from the front to the back, token codes and
// register indexes. Depends on nothing.
package rcre_pkg;

    // Widths of the fixed fields.
    localparam int COL_W      = 12;
    localparam int PIX_W      = 24;
    localparam int CNT_W      = 12;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 12;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0]  CFG_ROW_WIDTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_ROW_TOTAL = 8'd1;
    localparam logic [CFG_DATA_W-1:0] ROW_WIDTH_RST = 12'd1920;
    localparam logic [CFG_DATA_W-1:0] ROW_TOTAL_RST = 12'd1080;
    localparam logic [CFG_DATA_W-1:0] MIN_WIDTH     = 12'd3;

    // Command kinds in the queue.
    localparam logic [1:0] CMD_TAKE = 2'd0;
    localparam logic [1:0] CMD_ROW  = 2'd1;
    localparam logic [1:0] CMD_IMG  = 2'd2;

    // Kinds of pending run.
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_COPY    = 2'd1;
    localparam logic [1:0] KIND_REPEAT  = 2'd2;
    localparam logic [1:0] KIND_LITERAL = 2'd3;

    // Count byte coding.
    localparam logic [CNT_W-1:0] CNT_SPLIT   = 12'd128;
    localparam logic [7:0]       CNT_LOW_MSK = 8'h7f;
    localparam logic [7:0]       CNT_EXT_BIT = 8'h80;

    // One unit of work for the back part.
    typedef struct packed {
        logic [1:0]       kind;
        logic [COL_W-1:0] j;
        logic [PIX_W-1:0] p0;
        logic [PIX_W-1:0] p1;
        logic [PIX_W-1:0] p2;
        logic             up;
        logic             n1;
        logic             n2;
        logic             w4;
        logic             step_end;
    } cmd_t;

endpackage

[src/rcre_if.sv]
// Channel interfaces of the encoder: pixel requests, output bytes, register writes.
// Depends on rcre_pkg for the register port widths.
interface rcre_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] chan_first;
    logic [7:0] chan_second;
    logic [7:0] chan_third;
    modport source (output valid, chan_first, chan_second, chan_third, input ready);
    modport sink (input valid, chan_first, chan_second, chan_third, output ready);
endinterface

interface rcre_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       image_done;
    modport source (output valid, out_byte, last_of_run, image_done, input ready);
    modport sink (input valid, out_byte, last_of_run, image_done, output ready);
endinterface

interface rcre_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rcre_pkg::CFG_IDX_W-1:0]   index;
    logic [rcre_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[src/rcre_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module rcre_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/rcre_queue.sv]
// Short command queue between the front and the back of the encoder.
// Depends on rcre_pkg for the command type.
module rcre_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rcre_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output rcre_pkg::cmd_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rcre_pkg::cmd_t mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[src/rcre_front.sv]
// Front of the encoder: takes pixel requests and register writes, tracks the image
// position and lookahead, and queues column, row and image commands. Uses rcre_pkg.
module rcre_front #(
    parameter int LINE_DEPTH = 2048
) (
    input  logic           clk,
    input  logic           rst_n,
    rcre_pix_if.sink       pix,
    rcre_cfg_if.sink       cfg,
    output logic           push,
    output rcre_pkg::cmd_t push_data,
    input  logic           full
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int WW = AW + 1;
    localparam int RW = rcre_pkg::CFG_DATA_W;
    localparam int PW = rcre_pkg::PIX_W;

    localparam logic [2:0] F_IN  = 3'd0;
    localparam logic [2:0] F_T0  = 3'd1;
    localparam logic [2:0] F_T1  = 3'd2;
    localparam logic [2:0] F_T2  = 3'd3;
    localparam logic [2:0] F_ROW = 3'd4;
    localparam logic [2:0] F_IMG = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [RW-1:0] row_width_reg, row_total_reg;
    logic [WW-1:0] w_reg, w_next;
    logic [RW-1:0] rows_reg, rows_next;
    logic [AW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [PW-1:0] older_reg, older_next, newer_reg, newer_next;
    logic [AW-1:0] c_reg, c_next;
    logic [PW-1:0] px_reg, px_next, po_reg, po_next, pn_reg, pn_next;
    logic          up_reg, up_next;
    logic          row_end_reg, row_end_next;
    logic          img_end_reg, img_end_next;

    logic          accept;
    logic          first;
    logic [12:0]   w_cfg, w_cl, j13;
    logic [WW-1:0] w_eff;
    logic [RW-1:0] rows_eff;
    logic          at_row_end, at_img_end;
    logic [PW-1:0] pix_in;

    assign pix.ready = (state_reg == F_IN);
    assign cfg.ready = 1'b1;
    assign accept    = pix.valid && pix.ready;
    assign pix_in    = {pix.chan_first, pix.chan_second, pix.chan_third};

    // Image geometry, latched at the first pixel of an image.
    always_comb
    begin
        first = (col_reg == '0) && (row_reg == '0);
        w_cfg = {1'b0, row_width_reg};
        if (w_cfg < {1'b0, rcre_pkg::MIN_WIDTH})
        begin
            w_cl = {1'b0, rcre_pkg::MIN_WIDTH};
        end
        else if (w_cfg > 13'(LINE_DEPTH))
        begin
            w_cl = 13'(LINE_DEPTH);
        end
        else
        begin
            w_cl = w_cfg;
        end
        w_eff      = first ? w_cl[WW-1:0] : w_reg;
        rows_eff   = first ? ((row_total_reg == '0) ? RW'(1) : row_total_reg) : rows_reg;
        at_row_end = (13'(col_reg) + 13'd1) >= 13'(w_eff);
        at_img_end = at_row_end && ((13'(row_reg) + 13'd1) >= 13'(rows_eff));
    end

    // Column command built for the current push state.
    always_comb
    begin
        push_data          = '0;
        push_data.kind     = rcre_pkg::CMD_TAKE;
        push_data.up       = up_reg;
        j13                = 13'(c_reg);
        case (state_reg)
            F_T0:
            begin
                j13          = 13'(c_reg) - 13'd2;
                push_data.p0 = po_reg;
                push_data.p1 = pn_reg;
                push_data.p2 = px_reg;
                push_data.step_end = !row_end_reg;
            end
            F_T1:
            begin
                j13          = 13'(c_reg) - 13'd1;
                push_data.p0 = pn_reg;
                push_data.p1 = px_reg;
            end
            F_T2:
            begin
                push_data.p0 = px_reg;
            end
            F_ROW:
            begin
                push_data.kind     = rcre_pkg::CMD_ROW;
                push_data.step_end = !img_end_reg;
            end
            F_IMG:
            begin
                push_data.kind     = rcre_pkg::CMD_IMG;
                push_data.step_end = 1'b1;
            end
            default:
            begin
                push_data.kind = rcre_pkg::CMD_TAKE;
            end
        endcase
        push_data.j  = j13[rcre_pkg::COL_W-1:0];
        push_data.n1 = (j13 + 13'd1) < 13'(w_reg);
        push_data.n2 = (j13 + 13'd2) < 13'(w_reg);
        push_data.w4 = (j13 + 13'd4) == 13'(w_reg);
        push = (state_reg != F_IN) && !full;
    end

    // Sequencing of accepted pixels into commands.
    always_comb
    begin
        state_next   = state_reg;
        w_next       = w_reg;
        rows_next    = rows_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        older_next   = older_reg;
        newer_next   = newer_reg;
        c_next       = c_reg;
        px_next      = px_reg;
        po_next      = po_reg;
        pn_next      = pn_reg;
        up_next      = up_reg;
        row_end_next = row_end_reg;
        img_end_next = img_end_reg;
        case (state_reg)
            F_IN:
            begin
                if (accept)
                begin
                    w_next       = w_eff;
                    rows_next    = rows_eff;
                    c_next       = col_reg;
                    px_next      = pix_in;
                    po_next      = older_reg;
                    pn_next      = newer_reg;
                    up_next      = (row_reg != '0);
                    row_end_next = at_row_end;
                    img_end_next = at_img_end;
                    if (at_row_end)
                    begin
                        col_next   = '0;
                        older_next = '0;
                        newer_next = '0;
                        row_next   = at_img_end ? '0 : row_reg + 1'b1;
                        state_next = F_T0;
                    end
                    else
                    begin
                        col_next   = col_reg + 1'b1;
                        older_next = newer_reg;
                        newer_next = pix_in;
                        if (col_reg >= AW'(2))
                        begin
                            state_next = F_T0;
                        end
                    end
                end
            end
            F_T0:
            begin
                if (!full)
                begin
                    state_next = row_end_reg ? F_T1 : F_IN;
                end
            end
            F_T1:
            begin
                if (!full)
                begin
                    state_next = F_T2;
                end
            end
            F_T2:
            begin
                if (!full)
                begin
                    state_next = F_ROW;
                end
            end
            F_ROW:
            begin
                if (!full)
                begin
                    state_next = img_end_reg ? F_IMG : F_IN;
                end
            end
            F_IMG:
            begin
                if (!full)
                begin
                    state_next = F_IN;
                end
            end
            default:
            begin
                state_next = F_IN;
            end
        endcase
    end

    // Control state and registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IN;
            row_width_reg <= rcre_pkg::ROW_WIDTH_RST;
            row_total_reg <= rcre_pkg::ROW_TOTAL_RST;
            w_reg         <= WW'(rcre_pkg::ROW_WIDTH_RST);
            rows_reg      <= rcre_pkg::ROW_TOTAL_RST;
            col_reg       <= '0;
            row_reg       <= '0;
            older_reg     <= '0;
            newer_reg     <= '0;
            row_end_reg   <= 1'b0;
            img_end_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            w_reg       <= w_next;
            rows_reg    <= rows_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            older_reg   <= older_next;
            newer_reg   <= newer_next;
            row_end_reg <= row_end_next;
            img_end_reg <= img_end_next;
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == rcre_pkg::CFG_ROW_WIDTH)
                begin
                    row_width_reg <= cfg.data;
                end
                else if (cfg.index == rcre_pkg::CFG_ROW_TOTAL)
                begin
                    row_total_reg <= cfg.data;
                end
            end
        end
    end

    // Payload of the pixel being split into commands.
    always_ff @(posedge clk)
    begin
        c_reg  <= c_next;
        px_reg <= px_next;
        po_reg <= po_next;
        pn_reg <= pn_next;
        up_reg <= up_next;
    end

endmodule

[src/rcre_back.sv]
// Back of the encoder: runs column commands against the previous-row RAM,
// tracks the pending run and literal store, and emits the byte stream.
// Uses rcre_pkg, rcre_byte_if and rcre_ram.
module rcre_back #(
    parameter int LINE_DEPTH  = 2048,
    parameter int MAX_LITERAL = 12
) (
    input  logic           clk,
    input  logic           rst_n,
    input  rcre_pkg::cmd_t head,
    input  logic           empty,
    output logic           pop,
    rcre_byte_if.source    enc
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int LW = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;
    localparam int PW = rcre_pkg::PIX_W;
    localparam int NW = rcre_pkg::CNT_W;

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_RD0  = 4'd1;
    localparam logic [3:0] B_RD1  = 4'd2;
    localparam logic [3:0] B_DEC  = 4'd3;
    localparam logic [3:0] B_Z    = 4'd4;
    localparam logic [3:0] B_ONE  = 4'd5;
    localparam logic [3:0] B_CLO  = 4'd6;
    localparam logic [3:0] B_CHI  = 4'd7;
    localparam logic [3:0] B_PIX  = 4'd8;
    localparam logic [3:0] B_PAD  = 4'd9;
    localparam logic [3:0] B_FIN  = 4'd10;

    logic [3:0]     state_reg, state_next;
    rcre_pkg::cmd_t cmd_reg, cmd_next;
    logic [PW-1:0]  a0_reg, a0_next;
    logic [1:0]     kind_reg, kind_next;
    logic [NW-1:0]  len_reg, len_next;
    logic [PW-1:0]  lit_reg [MAX_LITERAL];
    logic           t_z_reg, t_one_reg, t_cnt_reg, t_pix_reg, t_lit_reg, t_img_reg;
    logic           t_z_next, t_one_next, t_cnt_next, t_pix_next, t_lit_next, t_img_next;
    logic [NW-1:0]  t_cnt_val_reg, t_cnt_val_next;
    logic [LW-1:0]  k_reg, k_next;
    logic [1:0]     b_reg, b_next;
    logic [3:0]     pad_reg, pad_next;
    logic           hold_v_reg, hold_v_next;
    logic [7:0]     hold_byte_reg, hold_byte_next;
    logic           hold_done_reg, hold_done_next;
    logic           out_v_reg, out_v_next;
    logic [7:0]     out_byte_reg, out_byte_next;
    logic           out_last_reg, out_last_next;
    logic           out_done_reg, out_done_next;

    logic [PW-1:0]  ram_rdata;
    logic [AW-1:0]  ram_raddr;
    logic           ram_we;
    logic           lit_we;
    logic [LW-1:0]  lit_widx;

    logic [PW-1:0]  up0, up1;
    logic           s_copy, s_rep, s_lone, run_end;
    logic [1:0]     kind_e;
    logic [NW-1:0]  len_e, len_n;
    logic           push_ok, emit_ok, emit_go;
    logic [7:0]     e_byte;
    logic           e_done;
    logic [3:0]     pad_n;
    logic [PW-1:0]  pix_sel;
    logic           k_last;
    logic [3:0]     after_chi, after_one, first_st;

    // Previous row store.
    rcre_ram #(
        .WIDTH (PW),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cmd_reg.j[AW-1:0]),
        .wdata (cmd_reg.p0),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_raddr = (state_reg == B_RD0) ? cmd_reg.j[AW-1:0] : cmd_reg.j[AW-1:0] + 1'b1;
    assign ram_we    = (state_reg == B_DEC);

    assign enc.valid       = out_v_reg;
    assign enc.out_byte    = out_byte_reg;
    assign enc.last_of_run = out_last_reg;
    assign enc.image_done  = out_done_reg;

    // Token choice for one column.
    always_comb
    begin
        up0    = cmd_reg.up ? a0_reg : '0;
        up1    = (cmd_reg.up && cmd_reg.n1) ? ram_rdata : '0;
        s_copy = cmd_reg.up && (cmd_reg.p0 == up0);
        s_rep  = cmd_reg.n1 && (cmd_reg.p0 == cmd_reg.p1);
        s_lone = !cmd_reg.n2 || (cmd_reg.p1 == cmd_reg.p2) ||
                 (cmd_reg.up && (cmd_reg.p1 == up1));
        if (kind_reg == rcre_pkg::KIND_NONE)
        begin
            len_e = '0;
            if (s_copy)
            begin
                kind_e = rcre_pkg::KIND_COPY;
            end
            else if (s_rep)
            begin
                kind_e = rcre_pkg::KIND_REPEAT;
            end
            else if (s_lone)
            begin
                kind_e = rcre_pkg::KIND_NONE;
            end
            else
            begin
                kind_e = rcre_pkg::KIND_LITERAL;
            end
        end
        else
        begin
            kind_e = kind_reg;
            len_e  = len_reg;
        end
        len_n = len_e + 1'b1;
        case (kind_e)
            rcre_pkg::KIND_COPY:
            begin
                run_end = !cmd_reg.n1 || (cmd_reg.p1 != up1);
            end
            rcre_pkg::KIND_REPEAT:
            begin
                run_end = !cmd_reg.n1 || (cmd_reg.p1 != cmd_reg.p0);
            end
            rcre_pkg::KIND_LITERAL:
            begin
                run_end = (len_n >= NW'(MAX_LITERAL)) || !cmd_reg.n2 ||
                          (cmd_reg.p1 == cmd_reg.p2) || cmd_reg.w4;
            end
            default:
            begin
                run_end = 1'b1;
            end
        endcase
    end

    // Byte of the current emission step and the step after it.
    always_comb
    begin
        push_ok  = !out_v_reg || enc.ready;
        emit_ok  = !hold_v_reg || push_ok;
        pad_n    = pad_reg + 1'b1;
        pix_sel  = t_lit_reg ? lit_reg[k_reg] : cmd_reg.p0;
        k_last   = t_lit_reg ? (NW'(k_reg) == t_cnt_val_reg - 1'b1) : 1'b1;
        after_chi = t_pix_reg ? B_PIX :
                    ((t_img_reg && (pad_n != '0)) ? B_PAD : B_FIN);
        after_one = t_cnt_reg ? B_CLO : (t_pix_reg ? B_PIX : B_FIN);
        first_st  = t_z_next ? B_Z : (t_one_next ? B_ONE :
                    (t_cnt_next ? B_CLO : (t_pix_next ? B_PIX : B_FIN)));
        e_done    = 1'b0;
        case (state_reg)
            B_ONE:
            begin
                e_byte = 8'd1;
            end
            B_CLO:
            begin
                if (t_cnt_val_reg >= rcre_pkg::CNT_SPLIT)
                begin
                    e_byte = (t_cnt_val_reg[7:0] & rcre_pkg::CNT_LOW_MSK) |
                             rcre_pkg::CNT_EXT_BIT;
                end
                else
                begin
                    e_byte = t_cnt_val_reg[7:0];
                    e_done = t_img_reg && (pad_n == '0);
                end
            end
            B_CHI:
            begin
                e_byte = 8'(t_cnt_val_reg >> 7);
            end
            B_PIX:
            begin
                case (b_reg)
                    2'd0:    e_byte = pix_sel[23:16];
                    2'd1:    e_byte = pix_sel[15:8];
                    default: e_byte = pix_sel[7:0];
                endcase
            end
            B_PAD:
            begin
                e_byte = 8'd0;
                e_done = (pad_n == '0);
            end
            default:
            begin
                e_byte = 8'd0;
            end
        endcase
    end

    // Command sequencing, emission and output staging.
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        a0_next        = a0_reg;
        kind_next      = kind_reg;
        len_next       = len_reg;
        t_z_next       = t_z_reg;
        t_one_next     = t_one_reg;
        t_cnt_next     = t_cnt_reg;
        t_pix_next     = t_pix_reg;
        t_lit_next     = t_lit_reg;
        t_img_next     = t_img_reg;
        t_cnt_val_next = t_cnt_val_reg;
        k_next         = k_reg;
        b_next         = b_reg;
        pad_next       = pad_reg;
        hold_v_next    = hold_v_reg;
        hold_byte_next = hold_byte_reg;
        hold_done_next = hold_done_reg;
        out_v_next     = out_v_reg && !enc.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        pop            = 1'b0;
        lit_we         = 1'b0;
        lit_widx       = len_e[LW-1:0];
        emit_go        = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    cmd_next   = head;
                    k_next     = '0;
                    b_next     = '0;
                    t_z_next   = 1'b1;
                    t_one_next = 1'b0;
                    t_cnt_next = 1'b1;
                    t_pix_next = 1'b0;
                    t_lit_next = 1'b0;
                    t_img_next = 1'b0;
                    t_cnt_val_next = '0;
                    case (head.kind)
                        rcre_pkg::CMD_ROW:
                        begin
                            kind_next  = rcre_pkg::KIND_NONE;
                            state_next = B_Z;
                        end
                        rcre_pkg::CMD_IMG:
                        begin
                            t_one_next = 1'b1;
                            t_img_next = 1'b1;
                            state_next = B_Z;
                        end
                        default:
                        begin
                            state_next = B_RD0;
                        end
                    endcase
                end
            end
            B_RD0:
            begin
                state_next = B_RD1;
            end
            B_RD1:
            begin
                a0_next    = ram_rdata;
                state_next = B_DEC;
            end
            B_DEC:
            begin
                k_next         = '0;
                b_next         = '0;
                t_z_next       = 1'b0;
                t_one_next     = 1'b0;
                t_cnt_next     = 1'b0;
                t_pix_next     = 1'b0;
                t_lit_next     = 1'b0;
                t_img_next     = 1'b0;
                t_cnt_val_next = len_n;
                len_next       = len_n;
                kind_next      = run_end ? rcre_pkg::KIND_NONE : kind_e;
                case (kind_e)
                    rcre_pkg::KIND_COPY:
                    begin
                        t_z_next   = run_end;
                        t_one_next = run_end;
                        t_cnt_next = run_end;
                    end
                    rcre_pkg::KIND_REPEAT:
                    begin
                        t_cnt_next = run_end;
                        t_pix_next = run_end;
                    end
                    rcre_pkg::KIND_LITERAL:
                    begin
                        lit_we     = 1'b1;
                        t_z_next   = run_end;
                        t_cnt_next = run_end;
                        t_pix_next = run_end;
                        t_lit_next = run_end;
                    end
                    default:
                    begin
                        t_one_next = 1'b1;
                        t_pix_next = 1'b1;
                    end
                endcase
                state_next = first_st;
            end
            B_Z:
            begin
                emit_go = emit_ok;
                if (emit_ok)
                begin
                    state_next = t_one_reg ? B_ONE : after_one;
                end
            end
            B_ONE:
            begin
                emit_go = emit_ok;
                if (emit_ok)
                begin
                    state_next = after_one;
                end
            end
            B_CLO:
            begin
                emit_go = emit_ok;
                if (emit_ok)
                begin
                    state_next = (t_cnt_val_reg >= rcre_pkg::CNT_SPLIT) ? B_CHI : after_chi;
                end
            end
            B_CHI:
            begin
                emit_go = emit_ok;
                if (emit_ok)
                begin
                    state_next = after_chi;
                end
            end
            B_PIX:
            begin
                emit_go = emit_ok;
                if (emit_ok)
                begin
                    if (b_reg == 2'd2)
                    begin
                        b_next = '0;
                        if (k_last)
                        begin
                            state_next = B_FIN;
                        end
                        else
                        begin
                            k_next = k_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        b_next = b_reg + 1'b1;
                    end
                end
            end
            B_PAD:
            begin
                emit_go = emit_ok;
                if (emit_ok && (pad_n == '0))
                begin
                    state_next = B_FIN;
                end
            end
            B_FIN:
            begin
                if (!cmd_reg.step_end || !hold_v_reg)
                begin
                    state_next = B_IDLE;
                end
                else if (push_ok)
                begin
                    out_v_next    = 1'b1;
                    out_byte_next = hold_byte_reg;
                    out_last_next = 1'b1;
                    out_done_next = hold_done_reg;
                    hold_v_next   = 1'b0;
                    state_next    = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        // A new byte moves the held byte out; the last one of a step stays held.
        if (emit_go)
        begin
            if (hold_v_reg)
            begin
                out_v_next    = 1'b1;
                out_byte_next = hold_byte_reg;
                out_last_next = 1'b0;
                out_done_next = hold_done_reg;
            end
            hold_v_next    = 1'b1;
            hold_byte_next = e_byte;
            hold_done_next = e_done;
            pad_next       = pad_n;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            kind_reg   <= rcre_pkg::KIND_NONE;
            len_reg    <= '0;
            pad_reg    <= '0;
            hold_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            len_reg    <= len_next;
            pad_reg    <= pad_next;
            hold_v_reg <= hold_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        a0_reg        <= a0_next;
        t_z_reg       <= t_z_next;
        t_one_reg     <= t_one_next;
        t_cnt_reg     <= t_cnt_next;
        t_pix_reg     <= t_pix_next;
        t_lit_reg     <= t_lit_next;
        t_img_reg     <= t_img_next;
        t_cnt_val_reg <= t_cnt_val_next;
        k_reg         <= k_next;
        b_reg         <= b_next;
        hold_byte_reg <= hold_byte_next;
        hold_done_reg <= hold_done_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_done_reg  <= out_done_next;
        if (lit_we)
        begin
            lit_reg[lit_widx] <= cmd_reg.p0;
        end
    end

    // A pending literal never outgrows its store.
    a_lit_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (kind_reg == rcre_pkg::KIND_LITERAL) |-> (len_reg < NW'(MAX_LITERAL)))
        else $error("literal run longer than its store");

    // The end of the image is always the final byte of a step.
    a_done_last : assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_done_reg) |-> out_last_reg)
        else $error("image end flagged on a byte that does not close a step");

    // No run is left pending when a row or image code starts.
    a_row_clean : assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == B_IDLE) && !empty && (head.kind != rcre_pkg::CMD_TAKE))
        |-> (kind_reg == rcre_pkg::KIND_NONE))
        else $error("run still pending at row end");

    // The image end code leaves the byte count on a 16-byte boundary.
    a_pad_align : assert property (@(posedge clk) disable iff (!rst_n)
        (emit_go && e_done) |=> (pad_reg == '0))
        else $error("image did not end on a 16-byte boundary");

endmodule

[src/row_copy_run_length_image_encoder_unit.sv]
// Top level of the row-copy run-length image encoder.
// Depends on rcre_pkg, rcre_if, rcre_front, rcre_queue and rcre_back.
//
// Usage: pixels arrive in raster order on the pix channel (chan_first,
// chan_second, chan_third), one request per valid/ready handshake. The
// compressed stream leaves one byte per request on the enc channel;
// last_of_run marks the final byte caused by a pixel and image_done the last
// byte of an image. Register writes on the cfg channel set the row
// width (index 0) and row count (index 1); they take effect at the next image.
// The front takes a pixel and queues none, one, four or five commands (four or
// five when the pixel ends a row) in a four-entry queue. The back handles a
// column command in steps (pop, two reads of the previous-row RAM, a decision,
// the bytes it emits and a closing step); row and image end codes skip the
// reads and the decision. After reset the registers read 1920 and 1080 and
// the image position is at its first pixel. When the receiver stalls, one byte
// waits in the output register and one more in a holding register; the back
// then stops, the queue fills and pixel requests are held off.
module row_copy_run_length_image_encoder_unit #(
    parameter int LINE_DEPTH  = 2048,
    parameter int MAX_LITERAL = 12
) (
    input  logic       clk,
    input  logic       rst_n,
    rcre_pix_if.sink   pix,
    rcre_cfg_if.sink   cfg,
    rcre_byte_if.source enc
);

    rcre_pkg::cmd_t q_in, q_head;
    logic           q_push, q_full, q_pop, q_empty;

    // Pixel intake and command generation.
    rcre_front #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix),
        .cfg       (cfg),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full)
    );

    // Command queue.
    rcre_queue #(
        .DEPTH (4)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // Token decision and byte emission.
    rcre_back #(
        .LINE_DEPTH  (LINE_DEPTH),
        .MAX_LITERAL (MAX_LITERAL)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (q_head),
        .empty (q_empty),
        .pop   (q_pop),
        .enc   (enc)
    );

endmodule
